FILE: hdl/eac_pkg.sv
// ----------------------------------------------------------------------------
// eac_pkg: shared types, codes and character classes
// Payload structs, checker state, configuration registers and error codes
// for the mailbox address syntax checker.
// ----------------------------------------------------------------------------
package eac_pkg;

    // ---- payload ----------------------------------------------------------
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [4:0] error_code;
        logic [8:0] error_offset;
    } t_out;

    // ---- configuration ----------------------------------------------------
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_MAX = 2'd3;

    typedef struct packed {
        logic [6:0] local_max;
        logic [5:0] label_max;
        logic [7:0] domain_max;
        logic [8:0] address_max;
    } t_cfg;

    localparam t_cfg C_CFG_RESET = '{
        local_max:   7'd64,
        label_max:   6'd63,
        domain_max:  8'd255,
        address_max: 9'd256
    };

    // ---- error codes ------------------------------------------------------
    localparam logic [4:0] ERR_NONE            = 5'd0;
    localparam logic [4:0] ERR_LOCAL_EMPTY     = 5'd2;
    localparam logic [4:0] ERR_LOCAL_CHAR      = 5'd3;
    localparam logic [4:0] ERR_LOCAL_LONG      = 5'd4;
    localparam logic [4:0] ERR_LEAD_DOT        = 5'd5;
    localparam logic [4:0] ERR_TRAIL_DOT       = 5'd6;
    localparam logic [4:0] ERR_DOUBLE_DOT      = 5'd7;
    localparam logic [4:0] ERR_OPEN_QUOTE      = 5'd8;
    localparam logic [4:0] ERR_BAD_ESCAPE      = 5'd9;
    localparam logic [4:0] ERR_QUOTED_CHAR     = 5'd10;
    localparam logic [4:0] ERR_NO_AT           = 5'd11;
    localparam logic [4:0] ERR_DOMAIN_EMPTY    = 5'd13;
    localparam logic [4:0] ERR_DOMAIN_CHAR     = 5'd14;
    localparam logic [4:0] ERR_LABEL_EMPTY     = 5'd15;
    localparam logic [4:0] ERR_LABEL_LONG      = 5'd16;
    localparam logic [4:0] ERR_DOMAIN_LONG     = 5'd17;
    localparam logic [4:0] ERR_LEAD_HYPHEN     = 5'd18;
    localparam logic [4:0] ERR_TRAIL_HYPHEN    = 5'd19;
    localparam logic [4:0] ERR_LITERAL_EMPTY   = 5'd20;
    localparam logic [4:0] ERR_LITERAL_OPEN    = 5'd21;
    localparam logic [4:0] ERR_LITERAL_CHAR    = 5'd22;
    localparam logic [4:0] ERR_ADDRESS_LONG    = 5'd23;

    // ---- characters -------------------------------------------------------
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PMIN    = 8'h21;
    localparam logic [7:0] CH_PMAX    = 8'h7E;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    localparam logic [8:0] C_COUNT_SAT = 9'h1FF;

    // ---- checker state ----------------------------------------------------
    typedef enum logic [1:0] {
        PH_LOCAL,
        PH_DOMAIN,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        LM_START,
        LM_ATOM,
        LM_DOT,
        LM_QSTART,
        LM_QCHAR,
        LM_QESC
    } t_lmode;

    typedef enum logic [1:0] {
        DM_LSTART,
        DM_LCHAR,
        DM_LIT
    } t_dmode;

    typedef struct packed {
        t_phase     phase;
        t_lmode     local_mode;
        t_dmode     domain_mode;
        logic [6:0] local_count;
        logic [5:0] label_count;
        logic [8:0] domain_count;
        logic [8:0] position;
        logic       prev_hyphen;
        logic [4:0] first_error;
        logic [8:0] first_error_offset;
    } t_state;

    localparam t_state C_STATE_CLEAR = '{
        phase:              PH_LOCAL,
        local_mode:         LM_START,
        domain_mode:        DM_LSTART,
        local_count:        7'd0,
        label_count:        6'd0,
        domain_count:       9'd0,
        position:           9'd0,
        prev_hyphen:        1'b0,
        first_error:        ERR_NONE,
        first_error_offset: 9'd0
    };

    // ---- character classes ------------------------------------------------
    function automatic logic f_is_alnum(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic f_is_atext(input logic [7:0] c);
        return f_is_alnum(c) ||
               (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                          8'h2D, 8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F, 8'h60, 8'h7B,
                          8'h7C, 8'h7D, 8'h7E});
    endfunction

    function automatic logic f_is_qtext(input logic [7:0] c);
        return (c inside {[CH_SPACE:CH_PMAX]}) && (c != CH_QUOTE) && (c != CH_BSLASH);
    endfunction

    function automatic logic f_is_dlit(input logic [7:0] c);
        return (c inside {[CH_PMIN:CH_PMAX]}) && (c != CH_LBRACK) && (c != CH_RBRACK) &&
               (c != CH_BSLASH);
    endfunction

endpackage

FILE: hdl/eac_step.sv
// ----------------------------------------------------------------------------
// eac_step: one-byte state update and verdict
// Advances the local/domain parser by one byte, latches the first error and
// forms the verdict on the final byte of an address.
// ----------------------------------------------------------------------------
module eac_step (
    input  eac_pkg::t_state i_state,
    input  eac_pkg::t_cfg   i_cfg,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output eac_pkg::t_state o_state,
    output eac_pkg::t_out   o_result
);
    import eac_pkg::*;

    t_state     w_step;
    logic [4:0] w_err;
    logic [8:0] w_off;
    logic [8:0] w_len;

    // parser update and first-error latch
    always_comb begin
        w_step = i_state;
        w_err  = ERR_NONE;
        w_off  = i_state.position;
        if (i_state.first_error == ERR_NONE) begin
            case (i_state.phase)
                PH_LOCAL: begin
                    case (i_state.local_mode)
                        LM_START: begin
                            if (i_byte == CH_QUOTE) begin
                                w_step.local_mode = LM_QSTART;
                            end else if (i_byte == CH_DOT) begin
                                w_err = ERR_LEAD_DOT;
                            end else if (i_byte == CH_AT) begin
                                w_err = ERR_LOCAL_EMPTY;
                            end else if (f_is_atext(i_byte)) begin
                                w_step.local_mode  = LM_ATOM;
                                w_step.local_count = 7'd1;
                            end else begin
                                w_err = ERR_LOCAL_CHAR;
                            end
                        end
                        LM_ATOM: begin
                            if (i_byte == CH_AT) begin
                                w_step.phase = PH_DOMAIN;
                            end else if (i_byte == CH_DOT || f_is_atext(i_byte)) begin
                                if (i_byte == CH_DOT) w_step.local_mode = LM_DOT;
                                if (i_state.local_count >= i_cfg.local_max) begin
                                    w_err = ERR_LOCAL_LONG;
                                end else begin
                                    w_step.local_count = i_state.local_count + 7'd1;
                                end
                            end else begin
                                w_err = ERR_LOCAL_CHAR;
                            end
                        end
                        LM_DOT: begin
                            if (i_byte == CH_DOT) begin
                                w_err = ERR_DOUBLE_DOT;
                            end else if (i_byte == CH_AT) begin
                                w_err = ERR_TRAIL_DOT;
                            end else if (f_is_atext(i_byte)) begin
                                w_step.local_mode = LM_ATOM;
                                if (i_state.local_count >= i_cfg.local_max) begin
                                    w_err = ERR_LOCAL_LONG;
                                end else begin
                                    w_step.local_count = i_state.local_count + 7'd1;
                                end
                            end else begin
                                w_err = ERR_LOCAL_CHAR;
                            end
                        end
                        LM_QSTART: begin
                            if (i_byte == CH_QUOTE) begin
                                w_err = ERR_LOCAL_EMPTY;
                            end else if (i_byte == CH_BSLASH) begin
                                w_step.local_mode = LM_QESC;
                            end else if (f_is_qtext(i_byte)) begin
                                // first quoted byte is taken without a limit check
                                w_step.local_mode  = LM_QCHAR;
                                w_step.local_count = i_state.local_count + 7'd1;
                            end else begin
                                w_err = ERR_QUOTED_CHAR;
                            end
                        end
                        LM_QCHAR: begin
                            if (i_byte == CH_QUOTE) begin
                                w_step.local_mode = LM_ATOM;
                            end else if (i_byte == CH_BSLASH) begin
                                w_step.local_mode = LM_QESC;
                            end else if (f_is_qtext(i_byte)) begin
                                if (i_state.local_count >= i_cfg.local_max) begin
                                    w_err = ERR_LOCAL_LONG;
                                end else begin
                                    w_step.local_count = i_state.local_count + 7'd1;
                                end
                            end else begin
                                w_err = ERR_QUOTED_CHAR;
                            end
                        end
                        LM_QESC: begin
                            if (i_byte < CH_SPACE || i_byte > CH_PMAX) begin
                                w_err = ERR_BAD_ESCAPE;
                            end else begin
                                w_step.local_mode = LM_QCHAR;
                                if (i_state.local_count >= i_cfg.local_max) begin
                                    w_err = ERR_LOCAL_LONG;
                                end else begin
                                    w_step.local_count = i_state.local_count + 7'd1;
                                end
                            end
                        end
                        default: begin
                            w_err = ERR_LOCAL_CHAR;
                        end
                    endcase
                end
                PH_DOMAIN: begin
                    case (i_state.domain_mode)
                        DM_LSTART: begin
                            if (i_byte == CH_LBRACK) begin
                                w_step.domain_mode = DM_LIT;
                            end else if (i_byte == CH_DOT) begin
                                w_err = ERR_LABEL_EMPTY;
                            end else if (i_byte == CH_HYPHEN) begin
                                w_err = ERR_LEAD_HYPHEN;
                            end else if (f_is_alnum(i_byte)) begin
                                w_step.domain_mode  = DM_LCHAR;
                                w_step.label_count  = 6'd1;
                                w_step.domain_count = i_state.domain_count + 9'd1;
                            end else begin
                                w_err = ERR_DOMAIN_CHAR;
                            end
                        end
                        DM_LCHAR: begin
                            if (i_byte == CH_DOT) begin
                                if (i_state.prev_hyphen) begin
                                    w_off = i_state.position - 9'd1;
                                    w_err = ERR_TRAIL_HYPHEN;
                                end else begin
                                    w_step.domain_mode = DM_LSTART;
                                    w_step.label_count = 6'd0;
                                    if (i_state.domain_count >= {1'b0, i_cfg.domain_max}) begin
                                        w_err = ERR_DOMAIN_LONG;
                                    end else begin
                                        w_step.domain_count = i_state.domain_count + 9'd1;
                                    end
                                end
                            end else if (i_byte == CH_HYPHEN || f_is_alnum(i_byte)) begin
                                if (i_state.label_count >= i_cfg.label_max) begin
                                    w_err = ERR_LABEL_LONG;
                                end else if (i_state.domain_count >=
                                             {1'b0, i_cfg.domain_max}) begin
                                    w_err = ERR_DOMAIN_LONG;
                                end else begin
                                    w_step.label_count  = i_state.label_count + 6'd1;
                                    w_step.domain_count = i_state.domain_count + 9'd1;
                                end
                            end else begin
                                w_err = ERR_DOMAIN_CHAR;
                            end
                        end
                        DM_LIT: begin
                            if (i_byte == CH_RBRACK) begin
                                if (i_state.domain_count == 9'd0) begin
                                    w_err = ERR_LITERAL_EMPTY;
                                end else if (!i_last) begin
                                    w_err = ERR_LITERAL_CHAR;
                                end else begin
                                    w_step.phase = PH_DONE;
                                end
                            end else if (f_is_dlit(i_byte)) begin
                                if (i_state.domain_count < C_COUNT_SAT) begin
                                    w_step.domain_count = i_state.domain_count + 9'd1;
                                end
                            end else begin
                                w_err = ERR_LITERAL_CHAR;
                            end
                        end
                        default: begin
                            w_err = ERR_DOMAIN_CHAR;
                        end
                    endcase
                end
                default: ;
            endcase
        end
        if (w_err != ERR_NONE) begin
            w_step.first_error        = w_err;
            w_step.first_error_offset = w_off;
        end
    end

    // next stored state: advance position, or clear after the final byte
    always_comb begin
        o_state = w_step;
        if (i_last) begin
            o_state = C_STATE_CLEAR;
        end else begin
            o_state.prev_hyphen = (i_byte == CH_HYPHEN);
            if (i_state.position < i_cfg.address_max) begin
                o_state.position = i_state.position + 9'd1;
            end
        end
    end

    // verdict for the final byte
    assign w_len = i_state.position + 9'd1;

    always_comb begin
        o_result.error_code   = w_step.first_error;
        o_result.error_offset = w_step.first_error_offset;
        if (i_state.position >= i_cfg.address_max) begin
            o_result.error_code   = ERR_ADDRESS_LONG;
            o_result.error_offset = i_cfg.address_max;
        end else if (w_step.first_error == ERR_NONE) begin
            o_result.error_code   = ERR_NONE;
            o_result.error_offset = 9'd0;
            case (w_step.phase)
                PH_LOCAL: begin
                    if (w_step.local_mode == LM_QSTART || w_step.local_mode == LM_QCHAR ||
                        w_step.local_mode == LM_QESC) begin
                        o_result.error_code   = ERR_OPEN_QUOTE;
                        o_result.error_offset = w_len;
                    end else begin
                        o_result.error_code   = ERR_NO_AT;
                        o_result.error_offset = i_state.position;
                    end
                end
                PH_DOMAIN: begin
                    case (w_step.domain_mode)
                        DM_LSTART: begin
                            o_result.error_code   = ERR_DOMAIN_EMPTY;
                            o_result.error_offset = w_len;
                        end
                        DM_LCHAR: begin
                            if (i_byte == CH_HYPHEN) begin
                                o_result.error_code   = ERR_TRAIL_HYPHEN;
                                o_result.error_offset = i_state.position;
                            end
                        end
                        default: begin
                            o_result.error_code   = ERR_LITERAL_OPEN;
                            o_result.error_offset = w_len;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/email_address_syntax_checker.sv
// ----------------------------------------------------------------------------
// email_address_syntax_checker: streaming mailbox address checker
// Checks one address byte per transfer and gives one verdict per address.
//
//   channel   direction  handshake               payload
//   in        input      i_in_valid / o_in_stall  i_in_data  (byte_in, last)
//   out       output     o_out_valid / i_out_stall o_out_data (error_code, error_offset)
//   cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while no final byte is stalled; a byte is held in
// the input register and its verdict is registered in the result register.
// The combinational parser update between the two registers sets the rate.
// Reset is synchronous and active low; it restores register defaults.
// A stalled result holds the final byte of the next address in the input
// register; bytes that are not final keep flowing.
// ----------------------------------------------------------------------------
module email_address_syntax_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  eac_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output eac_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [eac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [eac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import eac_pkg::*;

    t_cfg   r_cfg;
    logic   r_in_valid;
    t_in    r_in_data;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_out   r_out_data;
    t_out   n_result;
    logic   w_out_free;
    logic   w_proceed;
    logic   w_in_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= C_CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOCAL_MAX:   r_cfg.local_max   <= i_cfg_data[6:0];
                CFG_LABEL_MAX:   r_cfg.label_max   <= i_cfg_data[5:0];
                CFG_DOMAIN_MAX:  r_cfg.domain_max  <= i_cfg_data[7:0];
                CFG_ADDRESS_MAX: r_cfg.address_max <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // a final byte needs a free result slot; other bytes always advance
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_proceed  = r_in_valid && (!r_in_data.last || w_out_free);
    assign o_in_stall = r_in_valid && !w_proceed;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_in_data;
        end
    end

    eac_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_byte   (r_in_data.byte_in),
        .i_last   (r_in_data.last),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_CLEAR;
        end else if (w_proceed) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && r_in_data.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && r_in_data.last) begin
            r_out_data <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proceed && r_in_data.last) |=> r_out_valid)
        else $error("final byte did not produce a result");

    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !(w_proceed && r_in_data.last)) |=> !r_out_valid)
        else $error("result repeated after transfer");

    a_ok_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code == ERR_NONE) |-> o_out_data.error_offset == 9'd0)
        else $error("clean verdict carries an offset");

    a_error_offset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.first_error == ERR_NONE) |-> (r_state.first_error_offset == 9'd0))
        else $error("offset latched without an error");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proceed) |=> (r_in_valid && $stable(r_in_data)))
        else $error("stalled byte lost from input register");
`endif

endmodule
